/* hw/rtl/gtf_pkg.sv */
// Shared types and constants for the grouped team FIFO.
package gtf_pkg;

  localparam int ELEM_W    = 10;
  localparam int TEAM_W    = 6;
  localparam int SLOT_W    = 10;
  localparam int NUM_ELEM  = 1024;
  localparam int NUM_TEAMS = 64;
  localparam int DEPTH     = 1024;
  localparam int TAG_W     = TEAM_W + 1;
  localparam int CNT_W     = SLOT_W + 1;
  localparam int OCNT_W    = TEAM_W + 1;

  typedef enum logic [1:0] {
    MODE_ASSIGN  = 2'd0,
    MODE_ENQUEUE = 2'd1,
    MODE_DEQUEUE = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_VALID = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FAULT = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ELEM_W-1:0] element_id;
    logic [TEAM_W-1:0] team_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ELEM_W-1:0] out_element;
  } out_item_t;

  // Request from the controller to the membership table.
  typedef struct packed {
    logic              wr_en;
    logic              clr_start;
    logic [ELEM_W-1:0] addr;
    logic [TAG_W-1:0]  wr_tag;
  } mt_req_t;

endpackage

/* hw/rtl/grouped_team_fifo.sv */
// Top level of the grouped team FIFO: controller, queue memories and output register.
// One transaction at a time is processed: each operation walks a chain of dependent
// registered memory reads (membership, team order ring, team pointers, slot links).
// A clear, and reset itself, run a sweep over all 1024 membership table entries
// during which no input is accepted; a clear returns its result after the sweep.
// The result waits in an output register, so a stalled result blocks only the next
// result, not the work in progress.
module grouped_team_fifo
  import gtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD1  = 7'b0000010,
    S_RD2  = 7'b0000100,
    S_RD3  = 7'b0001000,
    S_RD4  = 7'b0010000,
    S_RESP = 7'b0100000,
    S_CLR  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  out_item_t         res_r, res_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              clr_resp_r, clr_resp_nxt;
  logic [TEAM_W-1:0] t_r, t_nxt;
  logic [SLOT_W-1:0] s_r, s_nxt;
  logic              last_r, last_nxt;
  logic [NUM_TEAMS-1:0] waiting_r, waiting_nxt;
  logic [TEAM_W-1:0] ohead_r, ohead_nxt;
  logic [TEAM_W-1:0] otail_r, otail_nxt;
  logic [OCNT_W-1:0] ocount_r, ocount_nxt;
  logic [CNT_W-1:0]  recyc_r, recyc_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;

  // Membership table.
  mt_req_t           mt_req;
  logic [TAG_W-1:0]  mt_tag;
  logic              mt_busy;

  gtf_member u_member (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mt_req),
    .rd_tag (mt_tag),
    .busy   (mt_busy)
  );

  // Queue memories.
  logic [ELEM_W-1:0] slot_elem_mem [DEPTH];
  logic [SLOT_W-1:0] slot_next_mem [DEPTH];
  logic [SLOT_W-1:0] rstk_mem      [DEPTH];
  logic [SLOT_W-1:0] head_mem      [NUM_TEAMS];
  logic [SLOT_W-1:0] tail_mem      [NUM_TEAMS];
  logic [TEAM_W-1:0] ring_mem      [NUM_TEAMS];

  logic [ELEM_W-1:0] se_q;
  logic [SLOT_W-1:0] sn_q, rstk_q, head_q, tail_q;
  logic [TEAM_W-1:0] ring_q;

  logic [SLOT_W-1:0] slot_rd_addr, rstk_rd_addr;
  logic [TEAM_W-1:0] team_rd_addr;

  logic              se_we, sn_we, rstk_we, head_we, tail_we, ring_we;
  logic [SLOT_W-1:0] se_wa, sn_wa, rstk_wa;
  logic [SLOT_W-1:0] sn_wd, rstk_wd, head_wd, tail_wd;
  logic [TEAM_W-1:0] team_wa, ring_wa, ring_wd;

  logic [SLOT_W-1:0] alloc_slot;
  logic              store_full;
  logic [TEAM_W-1:0] t_cur;

  assign alloc_slot   = (recyc_r != '0) ? rstk_q : fresh_r[SLOT_W-1:0];
  assign store_full   = (recyc_r == '0) && (fresh_r == CNT_W'(DEPTH));
  assign t_cur        = (item_r.mode == MODE_ENQUEUE) ? TEAM_W'(mt_tag - 1'b1) : ring_q;
  assign rstk_rd_addr = SLOT_W'(recyc_r - 1'b1);
  assign team_rd_addr = t_cur;
  assign slot_rd_addr = head_q;

  // Controller: one transaction walks its reads, then commits all writes at once.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    clr_resp_nxt  = clr_resp_r;
    t_nxt         = t_r;
    s_nxt         = s_r;
    last_nxt      = last_r;
    waiting_nxt   = waiting_r;
    ohead_nxt     = ohead_r;
    otail_nxt     = otail_r;
    ocount_nxt    = ocount_r;
    recyc_nxt     = recyc_r;
    fresh_nxt     = fresh_r;

    mt_req.wr_en     = 1'b0;
    mt_req.clr_start = 1'b0;
    mt_req.addr      = item_r.element_id;
    mt_req.wr_tag    = TAG_W'(item_r.team_id) + 1'b1;

    se_we = 1'b0; sn_we = 1'b0; rstk_we = 1'b0;
    head_we = 1'b0; tail_we = 1'b0; ring_we = 1'b0;
    se_wa   = alloc_slot;
    sn_wa   = tail_q;
    sn_wd   = alloc_slot;
    rstk_wa = recyc_r[SLOT_W-1:0];
    rstk_wd = s_r;
    team_wa = t_r;
    head_wd = alloc_slot;
    tail_wd = alloc_slot;
    ring_wa = otail_r;
    ring_wd = t_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        res_nxt = '{status: ST_DONE, out_element: '0};
        case (mode_t'(item_r.mode))
          MODE_ASSIGN: begin
            mt_req.wr_en = 1'b1;
            state_nxt    = S_RESP;
          end
          MODE_ENQUEUE: begin
            state_nxt = S_RD2;
          end
          MODE_DEQUEUE: begin
            if (ocount_r == '0) begin
              res_nxt.status = ST_EMPTY;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_RD2;
            end
          end
          default: begin
            mt_req.clr_start = 1'b1;
            waiting_nxt      = '0;
            ohead_nxt        = '0;
            otail_nxt        = '0;
            ocount_nxt       = '0;
            recyc_nxt        = '0;
            fresh_nxt        = '0;
            clr_resp_nxt     = 1'b1;
            state_nxt        = S_CLR;
          end
        endcase
      end
      S_RD2: begin
        t_nxt = t_cur;
        if (item_r.mode == MODE_ENQUEUE && (mt_tag == '0 || store_full)) begin
          res_nxt.status = ST_FAULT;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_RD3;
        end
      end
      S_RD3: begin
        if (item_r.mode == MODE_ENQUEUE) begin
          // Commit an enqueue into the allocated slot.
          se_we = 1'b1;
          if (recyc_r != '0) begin
            recyc_nxt = recyc_r - 1'b1;
          end else begin
            fresh_nxt = fresh_r + 1'b1;
          end
          tail_we = 1'b1;
          if (waiting_r[t_r]) begin
            sn_we = 1'b1;
          end else begin
            head_we          = 1'b1;
            ring_we          = 1'b1;
            waiting_nxt[t_r] = 1'b1;
            otail_nxt        = otail_r + 1'b1;
            ocount_nxt       = ocount_r + 1'b1;
          end
          state_nxt = S_RESP;
        end else begin
          s_nxt     = head_q;
          last_nxt  = (head_q == tail_q);
          state_nxt = S_RD4;
        end
      end
      S_RD4: begin
        // Commit a dequeue: return the slot and advance the group or the order.
        res_nxt.status      = ST_VALID;
        res_nxt.out_element = se_q;
        rstk_we             = 1'b1;
        recyc_nxt           = recyc_r + 1'b1;
        if (last_r) begin
          waiting_nxt[t_r] = 1'b0;
          ohead_nxt        = ohead_r + 1'b1;
          ocount_nxt       = ocount_r - 1'b1;
        end else begin
          head_we = 1'b1;
          head_wd = sn_q;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_CLR: begin
        if (!mt_busy) begin
          clr_resp_nxt = 1'b0;
          state_nxt    = clr_resp_r ? S_RESP : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
      clr_resp_r  <= 1'b0;
      waiting_r   <= '0;
      ohead_r     <= '0;
      otail_r     <= '0;
      ocount_r    <= '0;
      recyc_r     <= '0;
      fresh_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_resp_r  <= clr_resp_nxt;
      waiting_r   <= waiting_nxt;
      ohead_r     <= ohead_nxt;
      otail_r     <= otail_nxt;
      ocount_r    <= ocount_nxt;
      recyc_r     <= recyc_nxt;
      fresh_r     <= fresh_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    t_r    <= t_nxt;
    s_r    <= s_nxt;
    last_r <= last_nxt;
  end

  // Slot memories and the recycled slot stack.
  always_ff @(posedge clk) begin
    if (se_we) begin
      slot_elem_mem[se_wa] <= item_r.element_id;
    end
    if (sn_we) begin
      slot_next_mem[sn_wa] <= sn_wd;
    end
    if (rstk_we) begin
      rstk_mem[rstk_wa] <= rstk_wd;
    end
    se_q   <= slot_elem_mem[slot_rd_addr];
    sn_q   <= slot_next_mem[slot_rd_addr];
    rstk_q <= rstk_mem[rstk_rd_addr];
  end

  // Team pointer memories and the team order ring.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[team_wa] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[team_wa] <= tail_wd;
    end
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    head_q <= head_mem[team_rd_addr];
    tail_q <= tail_mem[team_rd_addr];
    ring_q <= ring_mem[ohead_r];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Every team in the order ring is marked waiting, and no other.
  a_order_matches_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(waiting_r) == ocount_r)
    else $error("order count differs from number of waiting teams");

  // Recycled slots never outnumber slots handed out.
  a_slot_accounting: assert property (@(posedge clk) disable iff (!rst_n)
    (fresh_r <= CNT_W'(DEPTH)) && (recyc_r <= fresh_r))
    else $error("slot accounting out of range");

  // Only a dequeued element carries a nonzero element field.
  a_elem_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_VALID |-> out_data.out_element == '0)
    else $error("element field set on a non-dequeue result");

  // No transaction is accepted while the membership sweep runs.
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    mt_busy |-> !in_ready)
    else $error("input ready during membership sweep");
`endif

endmodule

/* hw/rtl/gtf_member.sv */
// Membership table: element id to team tag, with a clearing sweep.
module gtf_member
  import gtf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mt_req_t          req,
  output logic [TAG_W-1:0] rd_tag,
  output logic             busy
);

  logic [TAG_W-1:0]  mem [NUM_ELEM];
  logic              sweep_r, sweep_nxt;
  logic [ELEM_W-1:0] idx_r, idx_nxt;
  logic [TAG_W-1:0]  rd_tag_r;

  // The sweep runs after reset and after a clear request.
  always_comb begin
    sweep_nxt = sweep_r;
    idx_nxt   = idx_r;
    if (sweep_r) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_r == ELEM_W'(NUM_ELEM - 1)) begin
        sweep_nxt = 1'b0;
      end
    end else if (req.clr_start) begin
      sweep_nxt = 1'b1;
      idx_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= 1'b1;
      idx_r   <= '0;
    end else begin
      sweep_r <= sweep_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Table with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (sweep_r) begin
      mem[idx_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wr_tag;
    end
    rd_tag_r <= mem[req.addr];
  end

  assign rd_tag = rd_tag_r;
  assign busy   = sweep_r;

endmodule

/* tb/grouped_team_fifo_test.sv */
// Self-checking testbench for the grouped team FIFO with a team-queue predictor.
`timescale 1ns / 100ps

module grouped_team_fifo_test;
  import gtf_pkg::*;

  // Tracks the expected contents of the team queue and the results still owed.
  class team_queue_board;
    logic [TAG_W-1:0] member_of [NUM_ELEM];
    int               team_group [NUM_TEAMS][$];
    int               team_order [$];
    int               used_slots;
    out_item_t        owed [$];
    int               errors;

    function void wipe();
      foreach (member_of[i]) member_of[i] = '0;
      foreach (team_group[i]) team_group[i].delete();
      team_order.delete();
      used_slots = 0;
    endfunction

    // Works out the result of one accepted transaction and queues it.
    function void note_input(in_item_t it);
      out_item_t r;
      int        t;
      r = '0;
      case (mode_t'(it.mode))
        MODE_ASSIGN: begin
          member_of[it.element_id] = TAG_W'(it.team_id) + 1'b1;
          r.status = ST_DONE;
        end
        MODE_ENQUEUE: begin
          if (member_of[it.element_id] == '0 || used_slots >= DEPTH) begin
            r.status = ST_FAULT;
          end else begin
            t = member_of[it.element_id] - 1;
            if (team_group[t].size() == 0) team_order.push_back(t);
            team_group[t].push_back(it.element_id);
            used_slots++;
            r.status = ST_DONE;
          end
        end
        MODE_DEQUEUE: begin
          if (team_order.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            t = team_order[0];
            r.status = ST_VALID;
            r.out_element = ELEM_W'(team_group[t].pop_front());
            used_slots--;
            if (team_group[t].size() == 0) void'(team_order.pop_front());
          end
        end
        default: begin
          wipe();
          r.status = ST_DONE;
        end
      endcase
      owed.push_back(r);
    endfunction

    // Compares one accepted result with the oldest owed one.
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        $error("unexpected result status=%0d element=%0d", got.status, got.out_element);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.out_element !== want.out_element) begin
        $error("out_element: expected %0d, actual %0d", want.out_element, got.out_element);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_data;

  team_queue_board board;
  int              burst_left;
  int              stall_phase;
  bit              sink_on;

  grouped_team_fifo u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // When sink_on is set, the receiver alternates between stretches of random stalls and free stretches.
  always @(posedge clk) begin
    if (out_valid && out_ready) board.check_result(out_data);
    stall_phase <= stall_phase + 1;
    if (!sink_on) out_ready <= 1'b1;
    else if (stall_phase[9:8] == 2'd0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Sends one transaction, with burst gaps ahead of it.
  task automatic send(logic [1:0] m, logic [ELEM_W-1:0] e, logic [TEAM_W-1:0] t);
    in_item_t it;
    int       gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    it.mode = m;
    it.element_id = e;
    it.team_id = t;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    board.note_input(it);
  endtask

  // Stops sending and waits until every owed result is back.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  int                i;
  logic [ELEM_W-1:0] e;
  int                k;
  int                mix;
  logic [9:0]        pool [16];

  initial begin
    board = new();
    board.wipe();
    board.errors = 0;
    burst_left = 0;
    stall_phase = 0;
    sink_on = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty dequeue, unteamed enqueue, field extremes, reassignment, clear.
    send(MODE_DEQUEUE, 10'h3ff, 6'h3f);
    send(MODE_ENQUEUE, 10'd0, 6'd0);
    send(MODE_ASSIGN, 10'd0, 6'd0);
    send(MODE_ASSIGN, 10'h3ff, 6'h3f);
    send(MODE_ASSIGN, 10'h155, 6'h2a);
    send(MODE_ENQUEUE, 10'h3ff, 6'd0);
    send(MODE_ENQUEUE, 10'd0, 6'h3f);
    send(MODE_ENQUEUE, 10'h155, 6'd0);
    send(MODE_ENQUEUE, 10'h3ff, 6'd0);
    send(MODE_ASSIGN, 10'h3ff, 6'd5);
    send(MODE_ENQUEUE, 10'h3ff, 6'd0);
    send(MODE_ENQUEUE, 10'd0, 6'd0);
    for (i = 0; i < 7; i++) send(MODE_DEQUEUE, 10'd0, 6'd0);
    send(MODE_ENQUEUE, 10'h155, 6'd0);
    send(MODE_CLEAR, 10'h2aa, 6'h15);
    send(MODE_ENQUEUE, 10'h155, 6'd0);
    send(MODE_DEQUEUE, 10'd0, 6'd0);

    // Fill the store to the brim so that the full case answers, take some out, clear.
    sink_on = 1;
    send(MODE_ASSIGN, 10'd7, 6'd3);
    send(MODE_ASSIGN, 10'd8, 6'd4);
    for (i = 0; i < DEPTH + 2; i++) send(MODE_ENQUEUE, (i % 3 == 0) ? 10'd8 : 10'd7, 6'd0);
    drain();
    for (i = 0; i < 30; i++) send(MODE_DEQUEUE, 10'd0, 6'd0);
    send(MODE_CLEAR, 10'd0, 6'd0);

    // Hold the sender until every owed result is back.
    drain();

    // Random: assign a pool of 16 to random teams, often among the first six, then mostly enqueue and dequeue.
    for (i = 0; i < 250; i++) begin
      if (i % 300 == 0) begin
        for (k = 0; k < 16; k++) begin
          pool[k] = ELEM_W'($urandom_range(0, 1023));
          send(MODE_ASSIGN, pool[k],
               TEAM_W'($urandom_range(0, 63) % ($urandom_range(0, 1) ? 64 : 6)));
        end
      end
      mix = $urandom_range(0, 99);
      e = pool[$urandom_range(0, 15)];
      if (mix < 45) send(MODE_ENQUEUE, e, TEAM_W'($urandom()));
      else if (mix < 88) send(MODE_DEQUEUE, ELEM_W'($urandom()), TEAM_W'($urandom()));
      else if (mix < 94) send(MODE_ASSIGN, e, TEAM_W'($urandom_range(0, 63)));
      else if (mix < 98) send(MODE_ENQUEUE, ELEM_W'($urandom()), TEAM_W'($urandom()));
      else if (mix < 99) send(MODE_ASSIGN, ELEM_W'($urandom()), TEAM_W'($urandom()));
      else send(MODE_CLEAR, ELEM_W'($urandom()), TEAM_W'($urandom()));
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
